@@ rtl/video_slice_packet_repacker_core_defines.svh @@
// Assertion macros shared by the repacker RTL.
// Assumes clk_i and rst_ni are visible in the scope of each use.
`ifndef VIDEO_SLICE_PACKET_REPACKER_CORE_DEFINES_SVH
`define VIDEO_SLICE_PACKET_REPACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define VSPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vspr: assertion failed");
// Check that a condition implies another on the same edge.
`define VSPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vspr: implication failed");
`else
`define VSPR_ASSERT(lbl, prop)
`define VSPR_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

@@ rtl/vspr_pkg.sv @@
// Shared types and constants of the video slice packet repacker.
// No dependencies.
package vspr_pkg;

  localparam int unsigned HeaderBytes        = 20;
  localparam int unsigned HeaderLastIdx      = HeaderBytes - 1;
  localparam int unsigned TableBytesPerSlice = 8;
  localparam logic [15:0] FlagsWord          = 16'h0002;
  localparam int unsigned CmdDepth           = 4;
  localparam int unsigned CmdPtrBits         = $clog2(CmdDepth);
  localparam int unsigned CmdCntBits         = $clog2(CmdDepth + 1);
  localparam int unsigned IdxBits            = $clog2(HeaderBytes);

  typedef enum logic [1:0] {
    CmdHeader,
    CmdWord,
    CmdPayload
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        frame_start;
    logic [23:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_last;
    logic       length_error;
  } out_item_t;

  // Work item between classifier and emitter. data is sent MSB byte first.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;
    logic [8:0]  slices;
    logic        last;
    logic        err;
  } cmd_t;

endpackage

@@ rtl/vspr_front.sv @@
// Front end: tracks frame phase and turns accepted bytes into emit commands.
// Depends on vspr_pkg.
`include "video_slice_packet_repacker_core_defines.svh"

module vspr_front import vspr_pkg::*; #(
  parameter int unsigned LengthBits = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhValid,
    PhOffset,
    PhPayload
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [8:0]            slices_left_q, slices_left_d;
  logic [23:0]           word_q, word_d;
  logic [1:0]            pos_q, pos_d;
  logic [LengthBits-1:0] payload_left_q, payload_left_d;
  logic                  err_q, err_d;

  logic [8:0]            slices;
  logic [11:0]           need;
  logic [LengthBits-1:0] len;
  logic [LengthBits-1:0] pl_dec;
  logic [8:0]            sl_dec;

  assign slices = 9'(item_i.in_byte) + 9'd1;
  assign need   = 12'(slices) * 12'(TableBytesPerSlice) + 12'd1;
  assign len    = LengthBits'(item_i.frame_length);
  assign pl_dec = payload_left_q - LengthBits'(1);
  assign sl_dec = slices_left_q - 9'd1;

  always_comb begin
    phase_d        = phase_q;
    slices_left_d  = slices_left_q;
    word_d         = word_q;
    pos_d          = pos_q;
    payload_left_d = payload_left_q;
    err_d          = err_q;
    cmd_push_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.kind     = CmdPayload;
    if (accept_i) begin
      priority if (item_i.frame_start) begin
        // New frame: abandon anything in progress and emit the header.
        if (len < LengthBits'(need)) begin
          err_d          = 1'b1;
          payload_left_d = '0;
        end else begin
          err_d          = 1'b0;
          payload_left_d = len - LengthBits'(need);
        end
        slices_left_d = slices;
        word_d        = '0;
        pos_d         = '0;
        phase_d       = PhValid;
        cmd_push_o    = 1'b1;
        cmd_o.kind    = CmdHeader;
        cmd_o.data    = 32'(payload_left_d);
        cmd_o.slices  = slices;
        cmd_o.err     = err_d;
      end else begin
        unique case (phase_q)
          PhIdle: begin
            // Drop stray bytes.
          end
          PhPayload: begin
            payload_left_d = pl_dec;
            cmd_push_o     = 1'b1;
            cmd_o.kind     = CmdPayload;
            cmd_o.data     = {item_i.in_byte, 24'h0};
            cmd_o.last     = (pl_dec == '0);
            cmd_o.err      = err_q;
            if (pl_dec == '0) phase_d = PhIdle;
          end
          PhValid, PhOffset: begin
            if (pos_q != 2'd3) begin
              word_d[8*pos_q +: 8] = item_i.in_byte;
              pos_d                = pos_q + 2'd1;
            end else begin
              // Fourth byte: emit the word byte-reversed.
              cmd_push_o = 1'b1;
              cmd_o.kind = CmdWord;
              cmd_o.data = {item_i.in_byte, word_q};
              cmd_o.err  = err_q;
              word_d     = '0;
              pos_d      = '0;
              if (phase_q == PhValid) begin
                phase_d = PhOffset;
              end else begin
                slices_left_d = sl_dec;
                if (sl_dec == '0) begin
                  cmd_o.last = (payload_left_q == '0);
                  phase_d    = (payload_left_q == '0) ? PhIdle : PhPayload;
                end else begin
                  phase_d = PhValid;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      slices_left_q  <= '0;
      word_q         <= '0;
      pos_q          <= '0;
      payload_left_q <= '0;
      err_q          <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      slices_left_q  <= slices_left_d;
      word_q         <= word_d;
      pos_q          <= pos_d;
      payload_left_q <= payload_left_d;
      err_q          <= err_d;
    end
  end

  `VSPR_ASSERT_IMP(a_payload_nonzero, phase_q == PhPayload, payload_left_q != '0)

endmodule

@@ rtl/vspr_cmd_fifo.sv @@
// Short command queue between the front end and the byte emitter.
// Depends on vspr_pkg.
`include "video_slice_packet_repacker_core_defines.svh"

module vspr_cmd_fifo import vspr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t                  mem_q [CmdDepth];
  logic [CmdPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntBits-1:0] count_q;

  assign full_o       = (count_q == CmdCntBits'(CmdDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + CmdPtrBits'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + CmdPtrBits'(1);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CmdCntBits'(1);
        2'b01:   count_q <= count_q - CmdCntBits'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `VSPR_ASSERT(a_count_bound, count_q <= CmdCntBits'(CmdDepth))
  `VSPR_ASSERT_IMP(a_no_overflow, push_i, !full_o)
  `VSPR_ASSERT_IMP(a_no_underflow, pop_i, head_valid_o)

endmodule

@@ rtl/vspr_back.sv @@
// Back end: expands queued commands into output bytes through an output register.
// Depends on vspr_pkg.
`include "video_slice_packet_repacker_core_defines.svh"

module vspr_back import vspr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      pop_cmd_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  logic [IdxBits-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [IdxBits-1:0] last_idx;
  logic               at_end;
  logic               load;
  logic [7:0]         sel_byte;

  always_comb begin
    unique case (head_i.kind)
      CmdHeader:  last_idx = IdxBits'(HeaderLastIdx);
      CmdWord:    last_idx = IdxBits'(3);
      CmdPayload: last_idx = '0;
      default:    last_idx = '0;
    endcase
  end

  // Header layout: length word, six zero bytes, flags, zero word, slice count.
  always_comb begin
    sel_byte = 8'h00;
    unique case (head_i.kind)
      CmdHeader: begin
        if (idx_q < IdxBits'(4)) begin
          sel_byte = head_i.data[8*(3 - idx_q[1:0]) +: 8];
        end else if (idx_q == IdxBits'(10)) begin
          sel_byte = FlagsWord[15:8];
        end else if (idx_q == IdxBits'(11)) begin
          sel_byte = FlagsWord[7:0];
        end else if (idx_q == IdxBits'(18)) begin
          sel_byte = {7'h00, head_i.slices[8]};
        end else if (idx_q == IdxBits'(19)) begin
          sel_byte = head_i.slices[7:0];
        end
      end
      CmdWord:    sel_byte = head_i.data[8*(3 - idx_q[1:0]) +: 8];
      CmdPayload: sel_byte = head_i.data[31:24];
      default:    sel_byte = 8'h00;
    endcase
  end

  assign at_end    = (idx_q == last_idx);
  assign load      = head_valid_i && (!out_valid_q || pop);
  assign pop_cmd_o = load && at_end;

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d              = at_end ? '0 : idx_q + IdxBits'(1);
      out_d.out_byte     = sel_byte;
      out_d.packet_last  = head_i.last && at_end;
      out_d.length_error = head_i.err;
      out_valid_d        = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  `VSPR_ASSERT_IMP(a_mid_cmd_held, idx_q != '0, head_valid_i)

endmodule

@@ rtl/video_slice_packet_repacker_core.sv @@
// Video slice packet repacker: frame bytes in, decoder packet bytes out (uses vspr_pkg).
// Path: with nothing ahead of it, a byte's command is written into the queue at the
// edge that accepts it and is then loaded into the output register.
// Throughput: one byte in and one beat out per cycle on payload while pop is held high;
// a header makes 20 output bytes, a word 4, so the queue fills and the input stalls.
// Reset: rst_ni asynchronous active low clears phase, queue and output valid.
module video_slice_packet_repacker_core import vspr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  // Command path between the classifier and the emitter.
  logic cmd_push;
  cmd_t cmd;
  logic cmd_pop;
  logic head_valid;
  cmd_t head;
  logic accept;

  // Accept a byte whenever the queue has room; bytes that make no command
  // (stray bytes, the first three bytes of a table word) advance state only.
  assign accept = push && !full;

  vspr_front #(
    .LengthBits(LENGTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd)
  );

  // Hold commands while the emitter works through header and word bursts.
  vspr_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .cmd_i       (cmd),
    .pop_i       (cmd_pop),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // Emit one beat per cycle from the queue head into the output register while it is empty or popped.
  vspr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_cmd_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for video_slice_packet_repacker_core.
// Drives frame bytes through the push/full side, predicts every packet beat and
// checks it on the empty/pop side. Depends on vspr_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
  import vspr_pkg::*;

  localparam int unsigned LengthBits = 24;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandomBytes = 150;
  localparam int unsigned TailBytes = 40;
  localparam int unsigned SettleCycles = 12;

  // Phase of the frame parser as the predictor tracks it.
  typedef enum logic [1:0] {
    PhIdle,
    PhValid,
    PhOffset,
    PhPayload
  } parse_phase_e;

  // One input beat waiting to be sent; hold_for_drain holds it back until every
  // outstanding packet beat has come out.
  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } frame_beat_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item_o;

  frame_beat_t frame_beats_q[$];
  out_item_t   packet_q[$];
  frame_beat_t next_beat;

  // Predictor state, mirrors the parser inside the core.
  parse_phase_e            phase = PhIdle;
  logic [8:0]              slices_left = '0;
  logic [23:0]             word_bytes = '0;
  logic [1:0]              word_pos = '0;
  logic [LengthBits-1:0]   payload_left = '0;
  logic                    len_err = 1'b0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic        tail_part = 1'b0;

  video_slice_packet_repacker_core #(
    .LENGTH_BITS(LengthBits)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Packet prediction
  // ---------------------------------------------------------------------------

  // Append one expected packet beat; the error flag rides on every beat.
  function automatic void emit_beat(logic [7:0] value, logic last);
    out_item_t beat;
    beat.out_byte     = value;
    beat.packet_last  = last;
    beat.length_error = len_err;
    packet_q.push_back(beat);
  endfunction

  // Big-endian 32-bit word, never the last beat.
  function automatic void emit_be32(logic [31:0] word);
    emit_beat(word[31:24], 1'b0);
    emit_beat(word[23:16], 1'b0);
    emit_beat(word[15:8], 1'b0);
    emit_beat(word[7:0], 1'b0);
  endfunction

  // Advance the parser by one accepted frame byte and queue what it produces.
  function automatic void repack_byte(in_item_t beat);
    logic [8:0]  slices;
    logic [23:0] need;
    logic [23:0] frame_len;
    logic [23:0] table_word;
    logic        table_done;
    table_done = 1'b0;
    if (beat.frame_start) begin
      // Start byte: always restarts, even in the middle of a packet.
      slices    = {1'b0, beat.in_byte} + 9'd1;
      need      = 24'd1 + 24'(slices) * 24'(TableBytesPerSlice);
      frame_len = beat.frame_length;
      if (frame_len < need) begin
        len_err      = 1'b1;
        payload_left = '0;
      end else begin
        len_err      = 1'b0;
        payload_left = LengthBits'(frame_len - need);
      end
      slices_left = slices;
      word_bytes  = '0;
      word_pos    = '0;
      phase       = PhValid;
      emit_be32(32'(payload_left));
      emit_be32(32'd0);
      emit_beat(8'h00, 1'b0);
      emit_beat(8'h00, 1'b0);
      emit_beat(FlagsWord[15:8], 1'b0);
      emit_beat(FlagsWord[7:0], 1'b0);
      emit_be32(32'd0);
      emit_be32(32'(slices));
      return;
    end
    // Stray byte outside a frame: drop it.
    if (phase == PhIdle) begin
      return;
    end
    if (phase == PhPayload) begin
      payload_left = payload_left - 1'b1;
      emit_beat(beat.in_byte, payload_left == 0);
      if (payload_left == 0) begin
        phase = PhIdle;
      end
      return;
    end
    // Slice table: collect three bytes, flush the byte-reversed word on the fourth.
    if (word_pos < 2'd3) begin
      word_bytes = word_bytes | (24'(beat.in_byte) << (8 * word_pos));
      word_pos   = word_pos + 2'd1;
      return;
    end
    table_word = word_bytes;
    word_pos   = '0;
    word_bytes = '0;
    if (phase == PhValid) begin
      phase = PhOffset;
    end else begin
      slices_left = slices_left - 9'd1;
      if (slices_left == 0) begin
        table_done = 1'b1;
        phase      = (payload_left == 0) ? PhIdle : PhPayload;
      end else begin
        phase = PhValid;
      end
    end
    emit_beat(beat.in_byte, 1'b0);
    emit_beat(table_word[23:16], 1'b0);
    emit_beat(table_word[15:8], 1'b0);
    emit_beat(table_word[7:0], table_done && payload_left == 0);
  endfunction

  // Compare one popped beat against the oldest expected one.
  function automatic void check_beat(out_item_t got);
    out_item_t want;
    if (packet_q.size() == 0) begin
      $error("unexpected packet beat: out_byte %02h packet_last %0b length_error %0b",
             got.out_byte, got.packet_last, got.length_error);
      fail_count++;
      return;
    end
    want = packet_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
      fail_count++;
    end
    if (got.packet_last !== want.packet_last) begin
      $error("packet_last: expected %0b, got %0b", want.packet_last, got.packet_last);
      fail_count++;
    end
    if (got.length_error !== want.length_error) begin
      $error("length_error: expected %0b, got %0b", want.length_error, got.length_error);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // frame_length is don't-care off the start byte, so fill it with noise.
  function automatic void queue_byte(logic [7:0] value, logic start, logic [23:0] len,
                                     bit drain = 1'b0);
    frame_beat_t beat;
    beat.item.in_byte      = value;
    beat.item.frame_start  = start;
    beat.item.frame_length = start ? len : 24'($urandom);
    beat.hold_for_drain    = drain;
    frame_beats_q.push_back(beat);
  endfunction

  // Start byte followed by body_bytes random bytes (table words, then payload).
  function automatic void queue_frame(logic [7:0] slices_m1, logic [23:0] len,
                                      int unsigned body_bytes, bit drain = 1'b0);
    queue_byte(slices_m1, 1'b1, len, drain);
    for (int unsigned i = 0; i < body_bytes; i++) begin
      queue_byte(8'($urandom), 1'b0, '0);
    end
  endfunction

  function automatic void queue_random_frames(int unsigned target);
    int unsigned pick;
    int unsigned slices;
    int unsigned need;
    int unsigned extra;
    bit          first;
    first = 1'b1;
    while (frame_beats_q.size() < target) begin
      pick   = $urandom_range(0, 9);
      slices = $urandom_range(1, 3);
      need   = 1 + TableBytesPerSlice * slices;
      if (pick <= 6) begin
        // Well-formed frame with a short payload.
        extra = $urandom_range(0, 6);
        queue_frame(8'(slices - 1), 24'(need + extra), need - 1 + extra, first);
      end else if (pick == 7) begin
        // Frame too short for its own slice table.
        queue_frame(8'(slices - 1), 24'($urandom_range(0, need - 1)), need - 1, first);
      end else if (pick == 8) begin
        // Random header, cut off by the next start byte.
        queue_frame(8'($urandom), 24'($urandom), $urandom_range(0, 12), first);
      end else begin
        // Loose bytes with no start: dropped when idle, content otherwise.
        for (int unsigned i = $urandom_range(1, 3); i > 0; i--) begin
          queue_byte(8'($urandom), 1'b0, '0, first);
        end
      end
      first = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: push side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Predict on the beat that the core takes at this edge.
      if (push && !full) begin
        repack_byte(in_item_i);
      end
      // Hold the current beat while the core is full.
      if (!(push && full)) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (frame_beats_q.size() != 0 &&
                     !(frame_beats_q[0].hold_for_drain && packet_q.size() != 0)) begin
          if (!tail_part && $urandom_range(0, 5) == 0) begin
            // Idle burst: push stays low while send_gap counts down.
            send_gap = $urandom_range(0, 2);
            push <= 1'b0;
          end else begin
            next_beat = frame_beats_q.pop_front();
            in_item_i <= next_beat.item;
            push <= 1'b1;
          end
        end else begin
          push <= 1'b0;
        end
      end
      tail_part <= frame_beats_q.size() < TailBytes;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pop side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        check_beat(out_item_o);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!tail_part && $urandom_range(0, 5) == 0) begin
        // Stall burst: pop stays low while recv_gap counts down.
        recv_gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a hung core must not stall the run forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed part.
    queue_byte(8'h5A, 1'b0, '0);            // stray byte while idle: dropped
    queue_frame(8'h00, 24'd0, 8);           // short frame, error on every beat
    queue_frame(8'h00, 24'd9, 8);           // exact fit: packet ends on the table
    queue_frame(8'hFF, 24'hFF_FFFF, 0);     // max slices and length, restarted at once
    queue_frame(8'h00, 24'd11, 8);          // two payload bytes at the byte extremes
    queue_byte(8'h00, 1'b0, '0);
    queue_byte(8'hFF, 1'b0, '0);
    // Random part; its first byte waits for the pipeline to drain.
    queue_random_frames(frame_beats_q.size() + RandomBytes);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken, every result to arrive, then settle.
    while (frame_beats_q.size() != 0 || push) begin
      @(posedge clk_i);
    end
    while (packet_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
